// ----- rtl/hsj_pkg.sv -----
// Shared constants, types and constant jitter tables for the Halton (2,3) jitter block.
// No dependencies; imported by halton_subpixel_jitter.
`timescale 1ns / 1ps
`default_nettype none

package hsj_pkg;

    // Sequence and fixed-point configuration
    localparam int MAX_PHASES    = 128;
    localparam int MIN_PHASES    = 8;
    localparam int PHASE_SCALE   = 8;
    localparam int FRACTION_BITS = 16;

    // Field widths
    localparam int DIM_W   = 14;
    localparam int FRAME_W = 31;

    // Phase count and sequence index widths
    localparam int PH_W  = $clog2(MAX_PHASES + 1);
    localparam int IDX_W = $clog2(MAX_PHASES);
    localparam int TAB_N = 1 << IDX_W;

    // Phase count divider widths
    localparam int SQ_W   = 2 * DIM_W;
    localparam int NUM_W  = SQ_W + $clog2(2 * PHASE_SCALE) + 1;
    localparam int DEN_W  = SQ_W + 1;
    localparam int CMP_W  = DEN_W + PH_W;
    localparam int STEP_W = (PH_W > 1) ? $clog2(PH_W) : 1;

    // Modulo pipeline: frame bits consumed per stage
    localparam int MOD_DIGITS = 4;
    localparam int MOD_ST     = (FRAME_W + MOD_DIGITS - 1) / MOD_DIGITS;
    localparam int FRM_PAD    = MOD_ST * MOD_DIGITS;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_DISPLAY_WIDTH = t_cfg_idx'(0);
    localparam t_cfg_idx REG_RENDER_WIDTH  = t_cfg_idx'(1);

    typedef logic [DIM_W-1:0]                 t_dim;
    typedef logic [FRAME_W-1:0]               t_frame;
    typedef logic signed [FRACTION_BITS-1:0]  t_jitter;
    typedef t_jitter                          t_jit_table [TAB_N];

    localparam longint SCALE = longint'(1) << FRACTION_BITS;
    localparam longint HALF  = SCALE >> 1;

    function automatic int ternary_digits();
        int     n;
        longint pw;
        n  = 0;
        pw = 1;
        while (pw <= longint'(TAB_N)) begin
            pw = pw * 3;
            n  = n + 1;
        end
        return n;
    endfunction

    function automatic longint pow3(int n);
        longint pw;
        pw = 1;
        for (int i = 0; i < n; i++) begin
            pw = pw * 3;
        end
        return pw;
    endfunction

    localparam int     DIGITS3 = ternary_digits();
    localparam longint DEN2    = longint'(1) << PH_W;
    localparam longint DEN3    = pow3(DIGITS3);

    // Base-2 radical inverse minus one half, table entry k is for index k+1
    function automatic t_jit_table build_x_table();
        t_jit_table tab;
        longint     num;
        longint     biased;
        longint     value;
        longint     idx;
        for (int k = 0; k < TAB_N; k++) begin
            idx = longint'(k + 1);
            num = 0;
            for (int b = 0; b < PH_W; b++) begin
                num = num * 2 + (idx % 2);
                idx = idx / 2;
            end
            biased = (2 * num * SCALE + DEN2) / (2 * DEN2);
            value  = biased - HALF;
            if (value > HALF - 1) value = HALF - 1;
            if (value < -HALF) value = -HALF;
            tab[k] = t_jitter'(value);
        end
        return tab;
    endfunction

    // Base-3 radical inverse minus one half, table entry k is for index k+1
    function automatic t_jit_table build_y_table();
        t_jit_table tab;
        longint     num;
        longint     biased;
        longint     value;
        longint     idx;
        for (int k = 0; k < TAB_N; k++) begin
            idx = longint'(k + 1);
            num = 0;
            for (int b = 0; b < DIGITS3; b++) begin
                num = num * 3 + (idx % 3);
                idx = idx / 3;
            end
            biased = (2 * num * SCALE + DEN3) / (2 * DEN3);
            value  = biased - HALF;
            if (value > HALF - 1) value = HALF - 1;
            if (value < -HALF) value = -HALF;
            tab[k] = t_jitter'(value);
        end
        return tab;
    endfunction

    localparam t_jit_table JIT_X_TABLE = build_x_table();
    localparam t_jit_table JIT_Y_TABLE = build_y_table();

endpackage

`default_nettype wire

// ----- rtl/halton_subpixel_jitter.sv -----
// Top level of the Halton (2,3) sub-pixel jitter generator.
// Depends on hsj_pkg for widths, register indexes and the jitter tables.
`timescale 1ns / 1ps
`default_nettype none

// Takes one frame number per cycle unless o_in_stall is high and returns one
// signed Q0.16 jitter pair per request, in order, through an input register,
// one modulo stage per four frame bits, and a registered table lookup.
// Stages hold their data under output stall and empty stages fill, so
// requests keep flowing into bubbles. After each write to display_width or
// render_width the phase count is recomputed by a sequential unit (a squaring
// state, a setup state, one range check, then, unless the check saturates,
// one restoring divide step per phase-count bit); during that time the frame
// input is stalled and the config port not ready.
// A render width of zero forces both offsets to zero.
module halton_subpixel_jitter (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // frame request channel
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire hsj_pkg::t_frame  i_frame_number,
    // jitter result channel
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output hsj_pkg::t_jitter      o_jitter_x,
    output hsj_pkg::t_jitter      o_jitter_y,
    // configuration write channel
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire hsj_pkg::t_cfg_idx i_cfg_index,
    input  wire hsj_pkg::t_dim    i_cfg_data
);

    import hsj_pkg::*;

    localparam int NS = MOD_ST + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_PREP,
        ST_CHECK,
        ST_DIVIDE
    } t_state;

    // ---------------------------------------------------------------
    // Configuration and phase count unit
    // ---------------------------------------------------------------
    t_state              r_state;
    t_dim                r_display;
    t_dim                r_render;
    logic [SQ_W-1:0]     r_dsq;
    logic [SQ_W-1:0]     r_rsq;
    logic [NUM_W-1:0]    r_num;
    logic [DEN_W-1:0]    r_den;
    logic [PH_W-1:0]     r_quot;
    logic [STEP_W-1:0]   r_step;
    logic [PH_W-1:0]     r_phases;

    logic                w_cfg_wr;
    logic                w_busy;
    logic [CMP_W-1:0]    w_den_sh;
    logic [CMP_W-1:0]    w_num_ext;
    logic                w_fits;
    logic [PH_W-1:0]     w_quot_next;
    logic                w_zero;

    assign w_busy    = (r_state != ST_IDLE);
    assign o_cfg_ready = !w_busy;
    assign w_cfg_wr  = i_cfg_valid && o_cfg_ready;
    assign w_zero    = (r_render == '0);

    assign w_num_ext = CMP_W'(r_num);
    assign w_den_sh  = CMP_W'(r_den) << r_step;
    assign w_fits    = (w_num_ext >= w_den_sh);

    always_comb begin
        w_quot_next = r_quot;
        if (w_fits) begin
            w_quot_next[r_step] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_display <= '0;
            r_render  <= '0;
            r_phases  <= PH_W'(MIN_PHASES);
            r_step    <= '0;
            r_quot    <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_cfg_wr) begin
                        unique case (i_cfg_index)
                            REG_DISPLAY_WIDTH: begin
                                r_display <= i_cfg_data;
                                r_state   <= ST_SQUARE;
                            end
                            REG_RENDER_WIDTH: begin
                                r_render <= i_cfg_data;
                                r_state  <= ST_SQUARE;
                            end
                            default: begin
                                // drop writes to unknown registers
                            end
                        endcase
                    end
                end
                ST_SQUARE: begin
                    r_dsq   <= SQ_W'(r_display) * SQ_W'(r_display);
                    r_rsq   <= SQ_W'(r_render) * SQ_W'(r_render);
                    r_state <= ST_PREP;
                end
                ST_PREP: begin
                    // round(8*(d/r)^2) = floor((16 d^2 + r^2) / (2 r^2))
                    r_num   <= NUM_W'(r_dsq) * NUM_W'(2 * PHASE_SCALE) + NUM_W'(r_rsq);
                    r_den   <= DEN_W'(r_rsq) << 1;
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    r_quot <= '0;
                    r_step <= STEP_W'(PH_W - 1);
                    if (w_num_ext >= CMP_W'(r_den) * CMP_W'(MAX_PHASES)) begin
                        // saturate at the top; also covers a zero render width
                        r_phases <= PH_W'(MAX_PHASES);
                        r_state  <= ST_IDLE;
                    end else begin
                        r_state <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE: begin
                    r_quot <= w_quot_next;
                    if (w_fits) begin
                        r_num <= NUM_W'(w_num_ext - w_den_sh);
                    end
                    if (r_step == '0) begin
                        r_phases <= (w_quot_next < PH_W'(MIN_PHASES)) ?
                                    PH_W'(MIN_PHASES) : w_quot_next;
                        r_state  <= ST_IDLE;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Request pipeline: input register, modulo stages, table lookup
    // ---------------------------------------------------------------
    function automatic logic [IDX_W-1:0] mod_step(
        input logic [IDX_W-1:0]      rem,
        input logic [MOD_DIGITS-1:0] bits,
        input logic [PH_W-1:0]       p
    );
        logic [PH_W:0] t;
        t = (PH_W + 1)'(rem);
        for (int i = MOD_DIGITS - 1; i >= 0; i--) begin
            t = {t[PH_W-1:0], bits[i]};
            if (t >= {1'b0, p}) begin
                t = t - {1'b0, p};
            end
        end
        return t[IDX_W-1:0];
    endfunction

    logic                 r_vld   [NS];
    logic [FRM_PAD-1:0]   r_frame [MOD_ST];
    logic [IDX_W-1:0]     r_rem   [1:MOD_ST];
    t_jitter              r_jx;
    t_jitter              r_jy;
    logic [NS:0]          w_ready;
    logic                 w_accept;

    always_comb begin
        w_ready[NS] = !i_out_stall;
        for (int s = NS - 1; s >= 0; s--) begin
            w_ready[s] = !r_vld[s] || w_ready[s+1];
        end
    end

    assign o_in_stall = !w_ready[0] || w_busy;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_ready[0]) begin
            r_vld[0] <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[0]) begin
            r_frame[0] <= FRM_PAD'(i_frame_number);
        end
    end

    for (genvar s = 1; s <= MOD_ST; s++) begin : g_mod
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (w_ready[s]) begin
                r_vld[s] <= r_vld[s-1];
            end
        end

        // consume the frame bits most significant first
        if (s == 1) begin : g_first
            always_ff @(posedge i_clk) begin
                if (w_ready[s]) begin
                    r_rem[s] <= mod_step('0, r_frame[0][FRM_PAD-1 -: MOD_DIGITS],
                                         r_phases);
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (w_ready[s]) begin
                    r_rem[s] <= mod_step(r_rem[s-1],
                                         r_frame[s-1][FRM_PAD-1-MOD_DIGITS*(s-1) -: MOD_DIGITS],
                                         r_phases);
                end
            end
        end

        if (s < MOD_ST) begin : g_pass
            always_ff @(posedge i_clk) begin
                if (w_ready[s]) begin
                    r_frame[s] <= r_frame[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[NS-1] <= 1'b0;
        end else if (w_ready[NS-1]) begin
            r_vld[NS-1] <= r_vld[NS-2];
        end
    end

    // table entry k holds the jitter for sequence index k+1
    always_ff @(posedge i_clk) begin
        if (w_ready[NS-1]) begin
            if (w_zero) begin
                r_jx <= '0;
                r_jy <= '0;
            end else begin
                r_jx <= JIT_X_TABLE[r_rem[MOD_ST]];
                r_jy <= JIT_Y_TABLE[r_rem[MOD_ST]];
            end
        end
    end

    assign o_out_valid = r_vld[NS-1];
    assign o_jitter_x  = r_jx;
    assign o_jitter_y  = r_jy;

endmodule

`default_nettype wire

// ----- test/tb_halton_subpixel_jitter.sv -----
// Self-checking testbench for halton_subpixel_jitter: directed table, then random frames.
// Depends on hsj_pkg and halton_subpixel_jitter; carries its own jitter predictor.
`timescale 1ns / 1ps

module tb_halton_subpixel_jitter;

    import hsj_pkg::t_dim;
    import hsj_pkg::t_frame;
    import hsj_pkg::t_jitter;
    import hsj_pkg::t_cfg_idx;
    import hsj_pkg::REG_DISPLAY_WIDTH;
    import hsj_pkg::REG_RENDER_WIDTH;

    localparam int        CLK_PERIOD    = 20;
    localparam int        RESET_CYCLES  = 10;
    localparam int        SETTLE_CYCLES = 16;
    localparam int        LONG_HOLD     = 100;
    localparam int        PHASE_COUNT   = 12;
    localparam int        PHASE_ITEMS   = 65;
    localparam longint    TIMEOUT_NS    = 10_000_000;
    localparam t_frame    FRAME_MAX     = '1;
    localparam t_dim      DIM_MAX       = '1;
    localparam longint    Q_ONE         = longint'(1) << hsj_pkg::FRACTION_BITS;
    localparam longint    Q_HALF        = Q_ONE >> 1;
    // indexes the block does not decode
    localparam t_cfg_idx  REG_SPARE_2   = t_cfg_idx'(2);
    localparam t_cfg_idx  REG_SPARE_3   = t_cfg_idx'(3);

    typedef struct packed {
        t_jitter x;
        t_jitter y;
    } t_jitter_pair;

    typedef struct {
        t_dim    disp;
        t_dim    rend;
        t_frame  frame;
        bit      literal;
        t_jitter jx;
        t_jitter jy;
    } t_directed_row;

    localparam int DIRECTED_ROWS = 23;

    // literal rows: zero render width, index 1, 2, 3 and 8 of the sequence
    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        '{14'd0,     14'd0,     31'd0,          1'b1, 16'sd0,      16'sd0},
        '{14'd0,     14'd0,     31'h7FFFFFFF,   1'b1, 16'sd0,      16'sd0},
        '{14'd100,   14'd0,     31'd12345,      1'b1, 16'sd0,      16'sd0},
        '{14'd16383, 14'd0,     31'h55555555,   1'b1, 16'sd0,      16'sd0},
        '{14'd0,     14'd1,     31'd0,          1'b1, 16'sd0,     -16'sd10923},
        '{14'd0,     14'd1,     31'd7,          1'b1, -16'sd28672, 16'sd25486},
        '{14'd0,     14'd1,     31'd8,          1'b1, 16'sd0,     -16'sd10923},
        '{14'd0,     14'd1,     31'h7FFFFFFF,   1'b1, -16'sd28672, 16'sd25486},
        '{14'd1,     14'd1,     31'd1,          1'b1, -16'sd16384, 16'sd10923},
        '{14'd1,     14'd1,     31'd2,          1'b1, 16'sd16384, -16'sd25486},
        '{14'd5,     14'd4,     31'd12,         1'b0, 16'sd0,      16'sd0},
        '{14'd5,     14'd4,     31'd13,         1'b1, 16'sd0,     -16'sd10923},
        '{14'd16383, 14'd1,     31'd127,        1'b0, 16'sd0,      16'sd0},
        '{14'd16383, 14'd1,     31'd128,        1'b1, 16'sd0,     -16'sd10923},
        '{14'd16383, 14'd1,     31'h7FFFFFFF,   1'b0, 16'sd0,      16'sd0},
        '{14'd16383, 14'd16383, 31'h2AAAAAAA,   1'b0, 16'sd0,      16'sd0},
        '{14'd16383, 14'd16383, 31'd9,          1'b1, -16'sd16384, 16'sd10923},
        '{14'd2,     14'd1,     31'd31,         1'b0, 16'sd0,      16'sd0},
        '{14'd2,     14'd1,     31'd32,         1'b1, 16'sd0,     -16'sd10923},
        '{14'd3,     14'd1,     31'd71,         1'b0, 16'sd0,      16'sd0},
        '{14'd3,     14'd1,     31'd72,         1'b1, 16'sd0,     -16'sd10923},
        '{14'd1,     14'd16383, 31'h40000000,   1'b1, 16'sd0,     -16'sd10923},
        '{14'd8191,  14'd16383, 31'h3FFFFFFF,   1'b0, 16'sd0,      16'sd0}
    };

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    t_frame   frame_number = '0;
    logic     out_stall = 1'b0;
    logic     cfg_valid = 1'b0;
    t_cfg_idx cfg_index = REG_DISPLAY_WIDTH;
    t_dim     cfg_data  = '0;

    logic     in_stall;
    logic     out_valid;
    logic     cfg_ready;
    t_jitter  jitter_x;
    t_jitter  jitter_y;

    // register copies as the block should hold them
    t_dim display_w = '0;
    t_dim render_w  = '0;

    t_jitter_pair pending_jitter [$];
    int           mismatch_count = 0;
    int           in_gap_max     = 5;
    int           out_gap_max    = 5;
    int           hold_requests  = 0;

    halton_subpixel_jitter dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_frame_number (frame_number),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_jitter_x     (jitter_x),
        .o_jitter_y     (jitter_y),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    initial begin
        forever begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    function automatic void radical_inverse(input longint unsigned idx,
                                            input longint unsigned base,
                                            output longint unsigned num,
                                            output longint unsigned den);
        num = 0;
        den = 1;
        while (idx > 0) begin
            num = num * base + idx % base;
            den = den * base;
            idx = idx / base;
        end
    endfunction

    // num/den - 1/2 in Q0.16, nearest with ties up, saturated
    function automatic t_jitter centred_q16(longint unsigned num, longint unsigned den);
        longint unsigned biased;
        longint          value;
        biased = (2 * num * Q_ONE + den) / (2 * den);
        value  = longint'(biased) - Q_HALF;
        if (value > Q_HALF - 1) value = Q_HALF - 1;
        if (value < -Q_HALF) value = -Q_HALF;
        return t_jitter'(value);
    endfunction

    function automatic t_jitter_pair predict_jitter(t_frame f);
        longint unsigned d;
        longint unsigned r2;
        longint unsigned phases;
        longint unsigned idx;
        longint unsigned num;
        longint unsigned den;
        t_jitter_pair    pair;
        if (render_w == 0) return '0;
        d      = longint'(display_w);
        r2     = longint'(render_w) * longint'(render_w);
        // round(8 * d^2 / r^2) in integers
        phases = (2 * hsj_pkg::PHASE_SCALE * d * d + r2) / (2 * r2);
        if (phases < hsj_pkg::MIN_PHASES) phases = hsj_pkg::MIN_PHASES;
        if (phases > hsj_pkg::MAX_PHASES) phases = hsj_pkg::MAX_PHASES;
        idx = longint'(f) % phases + 1;
        radical_inverse(idx, 2, num, den);
        pair.x = centred_q16(num, den);
        radical_inverse(idx, 3, num, den);
        pair.y = centred_q16(num, den);
        return pair;
    endfunction

    function automatic t_frame random_frame();
        case ($urandom_range(0, 3))
            0: return t_frame'($urandom_range(0, 300));
            1: return FRAME_MAX - t_frame'($urandom_range(0, 300));
            default: return t_frame'($urandom);
        endcase
    endfunction

    task automatic write_reg(t_cfg_idx idx, t_dim value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        if (idx == REG_DISPLAY_WIDTH) display_w = value;
        else if (idx == REG_RENDER_WIDTH) render_w = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // drop valid, drain every outstanding request, then let the pipeline empty
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_jitter.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_frame(t_frame f, bit literal, t_jitter_pair literal_pair);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        frame_number <= f;
        do @(posedge clk); while (in_stall !== 1'b0);
        pending_jitter.push_back(literal ? literal_pair : predict_jitter(f));
    endtask

    // result side: random stall per result, one long hold on request
    initial begin : result_sink
        int gap;
        int holds_done;
        holds_done = 0;
        forever begin
            gap = $urandom_range(0, out_gap_max);
            if (hold_requests != holds_done) begin
                holds_done = hold_requests;
                gap = LONG_HOLD;
            end
            if (gap > 0) begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    always @(posedge clk) begin : result_check
        t_jitter_pair want;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
            if (pending_jitter.size() == 0) begin
                $error("jitter pair with no request outstanding: x=%0d y=%0d",
                       jitter_x, jitter_y);
                mismatch_count++;
            end else begin
                want = pending_jitter.pop_front();
                if (jitter_x !== want.x) begin
                    $error("jitter_x: expected %0d, actual %0d", want.x, jitter_x);
                    mismatch_count++;
                end
                if (jitter_y !== want.y) begin
                    $error("jitter_y: expected %0d, actual %0d", want.y, jitter_y);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        t_directed_row row;
        t_jitter_pair  lit;
        t_dim          disp;
        t_dim          rend;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.disp != display_w || row.rend != render_w) begin
                settle();
                if (row.disp != display_w) write_reg(REG_DISPLAY_WIDTH, row.disp);
                if (row.rend != render_w) write_reg(REG_RENDER_WIDTH, row.rend);
            end
            lit.x = row.jx;
            lit.y = row.jy;
            send_frame(row.frame, row.literal, lit);
        end

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case ($urandom_range(0, 7))
                0: begin rend = '0; disp = t_dim'($urandom_range(0, DIM_MAX)); end
                1: begin disp = DIM_MAX; rend = t_dim'($urandom_range(1, DIM_MAX)); end
                2: begin rend = 14'd1; disp = t_dim'($urandom_range(0, DIM_MAX)); end
                3: begin disp = '0; rend = t_dim'($urandom_range(1, DIM_MAX)); end
                default: begin
                    // ratios from 0 to 4.5 so phase counts sweep the whole range
                    rend = t_dim'($urandom_range(1, 2000));
                    disp = t_dim'(((rend * $urandom_range(0, 45)) / 10 > DIM_MAX) ?
                                  DIM_MAX : (rend * $urandom_range(0, 45)) / 10);
                end
            endcase
            settle();
            if (p % 2 == 0) begin
                write_reg(REG_DISPLAY_WIDTH, disp);
                write_reg(REG_RENDER_WIDTH, rend);
            end else begin
                write_reg(REG_RENDER_WIDTH, rend);
                write_reg(REG_DISPLAY_WIDTH, disp);
            end
            if (p % 3 == 0) begin
                write_reg((p % 2 == 0) ? REG_SPARE_2 : REG_SPARE_3,
                          t_dim'($urandom_range(0, DIM_MAX)));
            end
            in_gap_max  = (p % 3 == 1 || p == 4) ? 0 : 5;
            out_gap_max = (p % 4 == 2) ? 0 : 5;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // back the result side up while frames keep coming
                if (p == 4 && n == 5) hold_requests++;
                send_frame(random_frame(), 1'b0, '0);
            end
        end

        settle();
        if (mismatch_count == 0) begin
            $display("halton_subpixel_jitter verification clean");
        end else begin
            $display("halton_subpixel_jitter verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("halton_subpixel_jitter verification failed");
        $finish;
    end

endmodule
